>>> rtl/core/sdfpd_pkg.sv
// shared types, constants and helper functions of the primitive distance block
`default_nettype none

package sdfpd_pkg;

  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int ROOT_W    = COORD_W;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int DIST_W    = COORD_W + 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = ADDR_W - 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(65536);

  typedef enum logic [1:0] {
    SHAPE_SPHERE,
    SHAPE_BOX,
    SHAPE_BOUND,
    SHAPE_CYLINDER
  } shape_t;

  typedef enum logic [1:0] {
    COMB_NONE,
    COMB_UNION,
    COMB_INTERSECT
  } comb_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SHAPE,
    REG_SIZE_X,
    REG_SIZE_Y,
    REG_SIZE_Z,
    REG_COMBINE
  } reg_idx_t;

  typedef struct packed {
    shape_t              shape;
    logic [SIZE_W-1:0]   size_x;
    logic [SIZE_W-1:0]   size_y;
    logic [SIZE_W-1:0]   size_z;
    comb_t               comb;
  } cfg_t;

  // fields that ride along with a request through the pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] prior;
    logic [COORD_W-1:0]        ay;
    logic signed [DIST_W-1:0]  dpre;
  } side_t;

  function automatic logic [COORD_W-1:0] mag(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] neg;
    neg = (~v) + COORD_W'(1);
    return v[COORD_W-1] ? neg : v;
  endfunction

  function automatic logic signed [DIST_W-1:0] ext_mag(input logic [COORD_W-1:0] v);
    return signed'({2'b00, v});
  endfunction

  function automatic logic signed [DIST_W-1:0] ext_size(input logic [SIZE_W-1:0] s);
    return signed'({3'b000, s});
  endfunction

  function automatic logic signed [DIST_W-1:0] ext_prior(
    input logic signed [COORD_W-1:0] p
  );
    return DIST_W'(p);
  endfunction

  function automatic logic signed [DIST_W-1:0] dmax(
    input logic signed [DIST_W-1:0] a,
    input logic signed [DIST_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [DIST_W-1:0] dmin(
    input logic signed [DIST_W-1:0] a,
    input logic signed [DIST_W-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  // positive part, known to fit in COORD_W bits wherever it is used
  function automatic logic [COORD_W-1:0] pos(input logic signed [DIST_W-1:0] d);
    return d[DIST_W-1] ? '0 : d[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sdf_primitive_distance_top.sv
// top level of the primitive signed distance pipeline
//
//  port group   dir    handshake                  content
//  apb          in/out psel penable pwrite pready shape, sizes, combine mode
//  request      in     req_valid / req_ready      point_x/y/z, prior_distance
//  result       out    res_valid / res_ready      distance, saturated
//
// one request per cycle while req_ready is high; a result passes through the two
// 32-stage root pipelines plus nine arithmetic and output stages
// rst is synchronous and clears all valid bits and loads the register defaults
// a stalled result holds; one more result parks in a skid slot, then req_ready drops
// registers are to be written only with no request in flight; the block does not enforce this
`default_nettype none

module sdf_primitive_distance_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sdfpd_pkg::ADDR_W-1:0]         paddr,
  input  logic [sdfpd_pkg::DATA_W-1:0]         pwdata,
  output logic [sdfpd_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_x,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_y,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_z,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] prior_distance,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [sdfpd_pkg::COORD_W-1:0] distance,
  output logic                                 saturated
);
  import sdfpd_pkg::*;

  cfg_t             cfg;
  logic             adv;
  logic             a_vld, ra_vld, b_vld, rb_vld;
  logic [RAD_W-1:0] a_rad, b_rad;
  logic [ROOT_W-1:0] a_root, b_root;
  side_t            a_side, ra_side, b_side, rb_side;

  assign req_ready = adv;

  sdfpd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdfpd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .cfg            (cfg),
    .vld            (req_valid),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .prior_distance (prior_distance),
    .rad_vld        (a_vld),
    .rad            (a_rad),
    .rad_side       (a_side)
  );

  sdfpd_isqrt u_root_a (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .vld       (a_vld),
    .rad       (a_rad),
    .side      (a_side),
    .root_vld  (ra_vld),
    .root      (a_root),
    .root_side (ra_side)
  );

  sdfpd_mid u_mid (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .cfg      (cfg),
    .vld      (ra_vld),
    .root     (a_root),
    .side     (ra_side),
    .rad_vld  (b_vld),
    .rad      (b_rad),
    .rad_side (b_side)
  );

  sdfpd_isqrt u_root_b (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .vld       (b_vld),
    .rad       (b_rad),
    .side      (b_side),
    .root_vld  (rb_vld),
    .root      (b_root),
    .root_side (rb_side)
  );

  sdfpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .vld       (rb_vld),
    .root      (b_root),
    .side      (rb_side),
    .adv       (adv),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .distance  (distance),
    .saturated (saturated)
  );

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_regs.sv
// apb configuration registers of the primitive distance block
`default_nettype none

module sdfpd_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sdfpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [sdfpd_pkg::DATA_W-1:0]  pwdata,
  output logic [sdfpd_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output sdfpd_pkg::cfg_t               cfg
);
  import sdfpd_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shape  <= SHAPE_SPHERE;
      cfg.size_x <= SIZE_RESET;
      cfg.size_y <= SIZE_RESET;
      cfg.size_z <= SIZE_RESET;
      cfg.comb   <= COMB_NONE;
    end else if (wr) begin
      case (idx)
        REG_SHAPE:   cfg.shape  <= shape_t'(pwdata[1:0]);
        REG_SIZE_X:  cfg.size_x <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:  cfg.size_y <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:  cfg.size_z <= pwdata[SIZE_W-1:0];
        REG_COMBINE: cfg.comb   <= comb_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SHAPE:   prdata = DATA_W'(cfg.shape);
      REG_SIZE_X:  prdata = DATA_W'(cfg.size_x);
      REG_SIZE_Y:  prdata = DATA_W'(cfg.size_y);
      REG_SIZE_Z:  prdata = DATA_W'(cfg.size_z);
      REG_COMBINE: prdata = DATA_W'(cfg.comb);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_front.sv
// input stages: magnitudes, per-shape operands, squares and their sum
`default_nettype none

module sdfpd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  sdfpd_pkg::cfg_t                     cfg,
  input  logic                                vld,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_x,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_y,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] point_z,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] prior_distance,
  output logic                                rad_vld,
  output logic [sdfpd_pkg::RAD_W-1:0]         rad,
  output sdfpd_pkg::side_t                    rad_side
);
  import sdfpd_pkg::*;

  // stage 0: magnitudes
  logic               v0;
  logic [COORD_W-1:0] ax0, ay0, az0;
  logic signed [COORD_W-1:0] prior0;

  // stage 1: operands to square
  logic               v1;
  logic [COORD_W-1:0] u0, u1, u2;
  side_t              side1;

  // stage 2: squares
  logic               v2;
  logic [RAD_W-1:0]   p0, p1, p2;
  side_t              side2;

  logic signed [DIST_W-1:0] dx, dy, dz, dm;
  logic [COORD_W-1:0]       u0_c, u1_c, u2_c;
  logic signed [DIST_W-1:0] dpre_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      rad_vld <= 1'b0;
    end else if (en) begin
      v0 <= vld;
      v1 <= v0;
      v2 <= v1;
      rad_vld <= v2;
    end
  end

  assign dx = ext_mag(ax0) - ext_size(cfg.size_x);
  assign dy = ext_mag(ay0) - ext_size(cfg.size_y);
  assign dz = ext_mag(az0) - ext_size(cfg.size_z);
  assign dm = dmax(dx, dmax(dy, dz));

  always_comb begin
    u0_c   = '0;
    u1_c   = '0;
    u2_c   = '0;
    dpre_c = '0;
    case (cfg.shape)
      SHAPE_SPHERE: begin
        u0_c = ax0;
        u1_c = ay0;
        u2_c = az0;
      end
      SHAPE_BOX: begin
        u0_c   = pos(dx);
        u1_c   = pos(dy);
        u2_c   = pos(dz);
        dpre_c = dmin(dm, '0);
      end
      SHAPE_BOUND: begin
        dpre_c = dm;
      end
      SHAPE_CYLINDER: begin
        // radial length in the xz plane first
        u0_c = ax0;
        u2_c = az0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax0    <= mag(point_x);
      ay0    <= mag(point_y);
      az0    <= mag(point_z);
      prior0 <= prior_distance;

      u0          <= u0_c;
      u1          <= u1_c;
      u2          <= u2_c;
      side1.prior <= prior0;
      side1.ay    <= ay0;
      side1.dpre  <= dpre_c;

      p0    <= RAD_W'(u0) * RAD_W'(u0);
      p1    <= RAD_W'(u1) * RAD_W'(u1);
      p2    <= RAD_W'(u2) * RAD_W'(u2);
      side2 <= side1;

      rad      <= p0 + p1 + p2;
      rad_side <= side2;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_isqrt.sv
// pipelined floor square root, one result bit per stage
`default_nettype none

module sdfpd_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld,
  input  logic [sdfpd_pkg::RAD_W-1:0]  rad,
  input  sdfpd_pkg::side_t             side,
  output logic                         root_vld,
  output logic [sdfpd_pkg::ROOT_W-1:0] root,
  output sdfpd_pkg::side_t             root_side
);
  import sdfpd_pkg::*;

  logic              vld_q  [0:ROOT_W-1];
  logic [ROOT_W:0]   rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [0:ROOT_W-1];
  side_t             side_q [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              vld_in;
    logic [ROOT_W:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    side_t             side_in;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+1:0] sub;
    logic [ROOT_W+2:0] diff;
    logic              fits;

    if (k == 0) begin : g_first
      assign vld_in  = vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_in = side;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next two radicand bits and try 4*root+1
    assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign sub   = {root_in, 2'b01};
    assign diff  = trial - {1'b0, sub};
    assign fits  = trial >= {1'b0, sub};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= fits ? diff[ROOT_W:0] : trial[ROOT_W:0];
        root_q[k] <= {root_in[ROOT_W-2:0], fits};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign root_vld  = vld_q[ROOT_W-1];
  assign root      = root_q[ROOT_W-1];
  assign root_side = side_q[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_mid.sv
// stages between the two roots: shape terms and the cylinder cap radicand
`default_nettype none

module sdfpd_mid (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  sdfpd_pkg::cfg_t              cfg,
  input  logic                         vld,
  input  logic [sdfpd_pkg::ROOT_W-1:0] root,
  input  sdfpd_pkg::side_t             side,
  output logic                         rad_vld,
  output logic [sdfpd_pkg::RAD_W-1:0]  rad,
  output sdfpd_pkg::side_t             rad_side
);
  import sdfpd_pkg::*;

  logic               v1, v2;
  logic [COORD_W-1:0] u0, u1;
  side_t              side1, side2;
  logic [RAD_W-1:0]   p0, p1;

  logic signed [DIST_W-1:0] rootd, dxc, dyc;
  logic signed [DIST_W-1:0] dpre_c;
  logic [COORD_W-1:0]       u0_c, u1_c;

  assign rootd = ext_mag(root);
  assign dxc   = rootd - ext_size(cfg.size_x);
  assign dyc   = ext_mag(side.ay) - ext_size(cfg.size_y);

  always_comb begin
    u0_c   = '0;
    u1_c   = '0;
    dpre_c = side.dpre;
    case (cfg.shape)
      SHAPE_SPHERE:   dpre_c = dxc;
      SHAPE_BOX:      dpre_c = side.dpre + rootd;
      SHAPE_BOUND:    dpre_c = side.dpre;
      SHAPE_CYLINDER: begin
        dpre_c = dmin(dmax(dxc, dyc), '0);
        u0_c   = pos(dxc);
        u1_c   = pos(dyc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rad_vld <= 1'b0;
    end else if (en) begin
      v1 <= vld;
      v2 <= v1;
      rad_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0          <= u0_c;
      u1          <= u1_c;
      side1.prior <= side.prior;
      side1.ay    <= side.ay;
      side1.dpre  <= dpre_c;

      p0    <= RAD_W'(u0) * RAD_W'(u0);
      p1    <= RAD_W'(u1) * RAD_W'(u1);
      side2 <= side1;

      rad      <= p0 + p1;
      rad_side <= side2;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_back.sv
// final distance, combine with prior, clamp, and the output buffer with skid
`default_nettype none

module sdfpd_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sdfpd_pkg::cfg_t                      cfg,
  input  logic                                 vld,
  input  logic [sdfpd_pkg::ROOT_W-1:0]         root,
  input  sdfpd_pkg::side_t                     side,
  output logic                                 adv,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic signed [sdfpd_pkg::COORD_W-1:0] distance,
  output logic                                 saturated
);
  import sdfpd_pkg::*;

  localparam logic signed [DIST_W-1:0] D_HI = DIST_W'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [DIST_W-1:0] D_LO = ~D_HI;

  logic                     v1;
  logic signed [DIST_W-1:0] dcomb;
  logic signed [DIST_W-1:0] d_c, dcomb_c, prior_c;

  logic signed [COORD_W-1:0] cl_dist;
  logic                      cl_sat;

  logic                      skid_v;
  logic signed [COORD_W-1:0] skid_dist;
  logic                      skid_sat;

  assign adv = !skid_v;

  assign prior_c = ext_prior(side.prior);
  assign d_c     = (cfg.shape == SHAPE_CYLINDER) ? side.dpre + ext_mag(root) : side.dpre;

  always_comb begin
    case (cfg.comb)
      COMB_UNION:     dcomb_c = dmin(d_c, prior_c);
      COMB_INTERSECT: dcomb_c = dmax(d_c, prior_c);
      default:        dcomb_c = d_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dcomb <= dcomb_c;
    end
  end

  always_comb begin
    cl_sat  = 1'b1;
    cl_dist = dcomb[COORD_W-1:0];
    if (dcomb > D_HI) begin
      cl_dist = D_HI[COORD_W-1:0];
    end else if (dcomb < D_LO) begin
      cl_dist = D_LO[COORD_W-1:0];
    end else begin
      cl_sat = 1'b0;
    end
  end

  // the skid slot takes the one request still leaving the pipe after a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_v) begin
        res_valid <= 1'b1;
        distance  <= skid_dist;
        saturated <= skid_sat;
        skid_v    <= 1'b0;
      end else begin
        res_valid <= v1;
        distance  <= cl_dist;
        saturated <= cl_sat;
      end
    end else if (v1 && !skid_v) begin
      skid_v    <= 1'b1;
      skid_dist <= cl_dist;
      skid_sat  <= cl_sat;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sdfpd_checker.sv
// port-level checks of the primitive distance block, bound to its top level
`default_nettype none

module sdfpd_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_ready,
  input  logic                                 res_valid,
  input  logic                                 res_ready,
  input  logic signed [sdfpd_pkg::COORD_W-1:0] distance,
  input  logic                                 saturated
);
  import sdfpd_pkg::*;

  localparam logic [COORD_W-1:0] MAX_D = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] MIN_D = ~MAX_D;

  // a held result keeps its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(distance) && $stable(saturated))
    else $error("result changed while stalled");

  // clamped results sit at one end of the range
  a_sat_ends: assert property (@(posedge clk) disable iff (rst)
    res_valid && saturated |-> distance == MAX_D || distance == MIN_D)
    else $error("saturated result not at a range limit");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // back pressure only while a result is waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> res_valid)
    else $error("request side stalled with no result pending");

  // ready drops only after the result side stalled
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(res_valid && !res_ready))
    else $error("request side stalled without a result stall");

endmodule

bind sdf_primitive_distance_top sdfpd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .distance  (distance),
  .saturated (saturated)
);

`default_nettype wire

>>> verif/tb.sv
// testbench for the primitive signed distance block: predictor, stimulus and result check
`timescale 1ns / 1ps

module tb;
  import sdfpd_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] prior;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] dval;
    logic                      sat;
  } dist_result_t;

  localparam int ONE = 1 << 16;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [1:0] COMB_MODE_THREE = 2'd3;
  localparam longint DIST_MAX = 64'sd2147483647;
  localparam longint DIST_MIN = -64'sd2147483648;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_ready;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic signed [COORD_W-1:0] prior_distance = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic signed [COORD_W-1:0] distance;
  logic saturated;

  // shadow of the block's registers, reset values
  shape_t            shape_cfg = SHAPE_SPHERE;
  logic [SIZE_W-1:0] size_x_cfg = SIZE_RESET;
  logic [SIZE_W-1:0] size_y_cfg = SIZE_RESET;
  logic [SIZE_W-1:0] size_z_cfg = SIZE_RESET;
  logic [1:0]        comb_cfg = COMB_NONE;

  dist_result_t distance_q[$];
  int mismatches = 0;
  int points_sent = 0;
  int results_checked = 0;
  int saturated_seen = 0;
  int shape_points[4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int stall_left = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  sdf_primitive_distance_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint abs_coord(input logic signed [COORD_W-1:0] v);
    longint w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic longint unsigned square(input longint v);
    longint unsigned u;
    u = v;
    return u * u;
  endfunction

  function automatic longint floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return longint'(root);
  endfunction

  function automatic longint higher(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lower(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint pos_part(input longint a);
    return (a > 0) ? a : 0;
  endfunction

  function automatic dist_result_t predict_distance(input point_t p);
    longint ax, ay, az, ex, ey, ez, radial, d;
    dist_result_t r;
    ax = abs_coord(p.x);
    ay = abs_coord(p.y);
    az = abs_coord(p.z);
    ex = ax - longint'(size_x_cfg);
    ey = ay - longint'(size_y_cfg);
    ez = az - longint'(size_z_cfg);
    case (shape_cfg)
      SHAPE_SPHERE: begin
        d = floor_root(square(ax) + square(ay) + square(az)) - longint'(size_x_cfg);
      end
      SHAPE_BOX: begin
        d = lower(higher(ex, higher(ey, ez)), 0)
            + floor_root(square(pos_part(ex)) + square(pos_part(ey)) + square(pos_part(ez)));
      end
      SHAPE_BOUND: begin
        d = higher(higher(ex, ey), ez);
      end
      default: begin
        // radial length is truncated before it enters the cap terms
        radial = floor_root(square(ax) + square(az));
        ex = radial - longint'(size_x_cfg);
        d = lower(higher(ex, ey), 0) + floor_root(square(pos_part(ex)) + square(pos_part(ey)));
      end
    endcase
    if (comb_cfg == COMB_UNION) d = lower(d, longint'(p.prior));
    else if (comb_cfg == COMB_INTERSECT) d = higher(d, longint'(p.prior));
    r.sat = 1'b0;
    if (d > DIST_MAX) begin
      d = DIST_MAX;
      r.sat = 1'b1;
    end else if (d < DIST_MIN) begin
      d = DIST_MIN;
      r.sat = 1'b1;
    end
    r.dval = COORD_W'(d);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 12 * ONE)) - 6 * ONE;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_MAX;
      2: return SIZE_W'($urandom());
      default: return SIZE_W'($urandom_range(1, 4 * ONE));
    endcase
  endfunction

  // lower valid when the current burst is cut short
  task automatic pause_requests();
    if (burst_left != 0) begin
      req_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic send_point(input point_t p);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    req_valid <= 1'b1;
    point_x <= p.x;
    point_y <= p.y;
    point_z <= p.z;
    prior_distance <= p.prior;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    distance_q.push_back(predict_distance(p));
    shape_points[int'(shape_cfg)]++;
    points_sent++;
    burst_left--;
    if (burst_left == 0) req_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    pause_requests();
    while (distance_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SHAPE:   shape_cfg = shape_t'(value[1:0]);
      REG_SIZE_X:  size_x_cfg = value[SIZE_W-1:0];
      REG_SIZE_Y:  size_y_cfg = value[SIZE_W-1:0];
      REG_SIZE_Z:  size_z_cfg = value[SIZE_W-1:0];
      REG_COMBINE: comb_cfg = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input shape_t shape, input logic [SIZE_W-1:0] sx,
                            input logic [SIZE_W-1:0] sy, input logic [SIZE_W-1:0] sz,
                            input logic [1:0] comb);
    wait_drained();
    write_reg(REG_SHAPE, DATA_W'(shape));
    write_reg(REG_SIZE_X, DATA_W'(sx));
    write_reg(REG_SIZE_Y, DATA_W'(sy));
    write_reg(REG_SIZE_Z, DATA_W'(sz));
    write_reg(REG_COMBINE, DATA_W'(comb));
  endtask

  task automatic test_reset_defaults();
    send_point('{2 * ONE, 0, 0, 0});
    send_point('{0, 0, 0, 0});
  endtask

  task automatic test_sphere();
    set_config(SHAPE_SPHERE, SIZE_MAX, ONE, ONE, COMB_NONE);
    send_point('{0, 0, 0, 0});
    send_point('{COORD_MIN, COORD_MIN, COORD_MIN, 0});
    // zero radius at the far corner overflows the range
    set_config(SHAPE_SPHERE, '0, ONE, ONE, COMB_NONE);
    send_point('{COORD_MIN, COORD_MIN, COORD_MIN, 0});
  endtask

  task automatic test_box();
    set_config(SHAPE_BOX, ONE, 2 * ONE, ONE / 2, COMB_NONE);
    send_point('{0, 0, 0, 0});
    send_point('{3 * ONE, -3 * ONE, 3 * ONE, 0});
    send_point('{-2 * ONE, ONE, 0, 0});
    send_point('{COORD_MAX, 0, COORD_MIN, 0});
  endtask

  task automatic test_bound();
    set_config(SHAPE_BOUND, ONE, 2 * ONE, ONE / 2, COMB_NONE);
    send_point('{0, 0, 0, 0});
    send_point('{-3 * ONE, ONE, 0, 0});
    set_config(SHAPE_BOUND, '0, '0, '0, COMB_NONE);
    send_point('{COORD_MAX, COORD_MIN, 0, 0});
  endtask

  task automatic test_cylinder();
    set_config(SHAPE_CYLINDER, ONE, 2 * ONE, '0, COMB_NONE);
    send_point('{0, 0, 0, 0});
    send_point('{3 * ONE, 0, 4 * ONE, 0});
    send_point('{0, -5 * ONE, 0, 0});
    send_point('{2 * ONE, 3 * ONE, 0, 0});
    send_point('{COORD_MIN, COORD_MAX, COORD_MIN, 0});
  endtask

  task automatic test_combine();
    set_config(SHAPE_SPHERE, ONE, ONE, ONE, COMB_UNION);
    send_point('{2 * ONE, 0, 0, -ONE});
    send_point('{2 * ONE, 0, 0, COORD_MAX});
    set_config(SHAPE_SPHERE, ONE, ONE, ONE, COMB_INTERSECT);
    send_point('{0, 0, 0, COORD_MIN});
    // clamp acts after the combine
    send_point('{COORD_MIN, COORD_MIN, COORD_MIN, ONE});
    set_config(SHAPE_SPHERE, ONE, ONE, ONE, COMB_MODE_THREE);
    send_point('{0, 0, 0, COORD_MIN});
  endtask

  task automatic test_random_phases();
    logic [SIZE_W-1:0] sx, sy, sz;
    point_t p;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        sx = '0;
        sy = '0;
        sz = '0;
      end else if (phase == 1) begin
        sx = SIZE_MAX;
        sy = SIZE_MAX;
        sz = SIZE_MAX;
      end else begin
        sx = pick_size();
        sy = pick_size();
        sz = pick_size();
      end
      set_config(shape_t'(2'(phase % 4)), sx, sy, sz, 2'($urandom_range(0, 3)));
      repeat (40) begin
        p.x = pick_coord();
        p.y = pick_coord();
        p.z = pick_coord();
        p.prior = pick_coord();
        send_point(p);
      end
    end
  endtask

  // result side: open stretches, choppy stretches and occasional long stalls
  always @(posedge clk) begin
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      res_ready <= 1'b0;
    end else if (rx_cycle % 300 < 100) begin
      res_ready <= 1'b1;
    end else if ($urandom_range(0, 60) == 0) begin
      stall_left = $urandom_range(10, 40);
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin : check_result
    dist_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (distance_q.size() == 0) begin
        $error("result with no request waiting: distance %0d", distance);
        mismatches++;
      end else begin
        want = distance_q.pop_front();
        if (distance !== want.dval) begin
          $error("distance: expected %0d, actual %0d", want.dval, distance);
          mismatches++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0b, actual %0b", want.sat, saturated);
          mismatches++;
        end
        results_checked++;
        if (saturated === 1'b1) saturated_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && req_ready) || (res_valid && res_ready)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("sdf_primitive_distance_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_sphere();
    test_box();
    test_bound();
    test_cylinder();
    test_combine();
    test_random_phases();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (distance_q.size() != 0) mismatches++;
    $display("checked %0d of %0d requests, %0d of them saturated",
             results_checked, points_sent, saturated_seen);
    $display("per shape: sphere %0d, box %0d, bound %0d, cylinder %0d",
             shape_points[0], shape_points[1], shape_points[2], shape_points[3]);
    if (mismatches == 0) begin
      $display("sdf_primitive_distance_top: match");
    end else begin
      $display("sdf_primitive_distance_top: mismatch");
    end
    $finish;
  end

endmodule
